// File: rtl/thread_scheduler_fifo_ready_queue_unit_macros.svh
// Assertion macros for the thread scheduler block.
// Used by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef THREAD_SCHEDULER_FIFO_READY_QUEUE_UNIT_MACROS_SVH
`define THREAD_SCHEDULER_FIFO_READY_QUEUE_UNIT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define TSQ_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tsq invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define TSQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsq sequence violated");

`endif

// File: rtl/tsq_pkg.sv
// Shared types and constants of the thread scheduler block.
// No dependencies; imported by tsq_ctrl and the top level.
package tsq_pkg;

	localparam int MAX_THREADS = 1024;
	localparam int TID_W       = $clog2(MAX_THREADS);
	localparam int CNT_W       = TID_W + 1;

	// command codes
	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_YIELD  = 2'd1;
	localparam logic [1:0] MODE_EXIT   = 2'd2;
	localparam logic [1:0] MODE_KILL   = 2'd3;

	// yield target kinds
	localparam logic [1:0] KIND_SPEC = 2'd0;
	localparam logic [1:0] KIND_ANY  = 2'd1;
	localparam logic [1:0] KIND_SELF = 2'd2;

	// per-thread state codes
	localparam logic [1:0] TS_FREE    = 2'd0;
	localparam logic [1:0] TS_READY   = 2'd1;
	localparam logic [1:0] TS_RUNNING = 2'd2;

	typedef enum logic [2:0] {
		STS_OK, STS_INVALID, STS_NONE, STS_NOFREE, STS_HALTED
	} sts_t;

	// one entry of the thread table
	typedef struct packed {
		logic [1:0]       st;
		logic             kill;
		logic [TID_W-1:0] nxt;
		logic [TID_W-1:0] prv;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef struct packed {
		logic             we;
		logic [TID_W-1:0] waddr;
		ent_t             wdata;
		logic [TID_W-1:0] raddr;
	} tmem_req_t;

	typedef struct packed {
		logic             we;
		logic [TID_W-1:0] waddr;
		logic [TID_W-1:0] wdata;
		logic [TID_W-1:0] raddr;
	} smem_req_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_CR, ST_ENQ_W, ST_ENQ_TW, ST_YCHK, ST_LOAD,
		ST_UL_H, ST_UL_HW, ST_UL_T, ST_UL_TW, ST_SW, ST_RUN, ST_PUSH,
		ST_DISP, ST_KCHK, ST_FIN
	} state_t;

endpackage

// File: rtl/tsq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tsq_ctrl.sv
// Command sequencer of the thread scheduler: read-modify-write over the thread table
// and the free-id stack. Depends on tsq_pkg and the assertion macro header.
`include "thread_scheduler_fifo_ready_queue_unit_macros.svh"

module tsq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic [1:0]                target_kind,
	input  logic [tsq_pkg::TID_W-1:0] target_tid,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                status,
	output logic [tsq_pkg::TID_W-1:0] result_tid,
	output logic [tsq_pkg::TID_W-1:0] running_tid,
	output tsq_pkg::tmem_req_t        a_req,
	input  logic [tsq_pkg::ENT_W-1:0] a_rdata,
	output tsq_pkg::smem_req_t        b_req,
	input  logic [tsq_pkg::TID_W-1:0] b_rdata
);
	import tsq_pkg::*;

	state_t           state_q, state_d, enq_ret_q, enq_ret_d, ul_ret_q, ul_ret_d;
	logic [TID_W-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d;
	logic [TID_W-1:0] tgt_q, tgt_d, enq_q, enq_d, res_q, res_d, clr_q, clr_d;
	logic [CNT_W-1:0] count_q, count_d, free_q, free_d;
	logic             halted_q, halted_d;
	sts_t             sts_q, sts_d, osts_q, osts_d;
	ent_t             e_q, e_d, rd;
	logic             ov_q, ov_d;
	logic [TID_W-1:0] ores_q, ores_d, orun_q, orun_d;
	logic             acc;

	assign rd       = ent_t'(a_rdata);
	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	assign out_valid   = ov_q;
	assign status      = osts_q;
	assign result_tid  = ores_q;
	assign running_tid = orun_q;

	// hold all state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			enq_ret_q <= ST_FIN;
			ul_ret_q  <= ST_RUN;
			head_q    <= '0;
			tail_q    <= '0;
			cur_q     <= '0;
			tgt_q     <= '0;
			enq_q     <= '0;
			res_q     <= '0;
			clr_q     <= '0;
			count_q   <= '0;
			free_q    <= CNT_W'(MAX_THREADS - 1);
			halted_q  <= 1'b0;
			sts_q     <= STS_OK;
			osts_q    <= STS_OK;
			e_q       <= '0;
			ov_q      <= 1'b0;
			ores_q    <= '0;
			orun_q    <= '0;
		end else begin
			state_q   <= state_d;
			enq_ret_q <= enq_ret_d;
			ul_ret_q  <= ul_ret_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			cur_q     <= cur_d;
			tgt_q     <= tgt_d;
			enq_q     <= enq_d;
			res_q     <= res_d;
			clr_q     <= clr_d;
			count_q   <= count_d;
			free_q    <= free_d;
			halted_q  <= halted_d;
			sts_q     <= sts_d;
			osts_q    <= osts_d;
			e_q       <= e_d;
			ov_q      <= ov_d;
			ores_q    <= ores_d;
			orun_q    <= orun_d;
		end
	end

	// sequence one command through the memories
	always_comb begin
		state_d   = state_q;
		enq_ret_d = enq_ret_q;
		ul_ret_d  = ul_ret_q;
		head_d    = head_q;
		tail_d    = tail_q;
		cur_d     = cur_q;
		tgt_d     = tgt_q;
		enq_d     = enq_q;
		res_d     = res_q;
		clr_d     = clr_q;
		count_d   = count_q;
		free_d    = free_q;
		halted_d  = halted_q;
		sts_d     = sts_q;
		osts_d    = osts_q;
		e_d       = e_q;
		ov_d      = ov_q && !out_ready;
		ores_d    = ores_q;
		orun_d    = orun_q;
		a_req     = '0;
		b_req     = '0;

		unique case (state_q)
			ST_INIT: begin
				// clear the thread table and fill the free stack
				a_req.we       = 1'b1;
				a_req.waddr    = clr_q;
				a_req.wdata.st = (clr_q == '0) ? TS_RUNNING : TS_FREE;
				b_req.we       = 1'b1;
				b_req.waddr    = clr_q;
				b_req.wdata    = ~clr_q;
				clr_d          = clr_q + 1'b1;
				if (clr_q == TID_W'(MAX_THREADS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					sts_d = STS_OK;
					res_d = '0;
					if (halted_q) begin
						state_d = ST_FIN;
					end else begin
						case (mode)
							MODE_CREATE: begin
								if (free_q == '0) begin
									sts_d   = STS_NOFREE;
									state_d = ST_FIN;
								end else begin
									free_d      = free_q - 1'b1;
									b_req.raddr = free_d[TID_W-1:0];
									state_d     = ST_CR;
								end
							end
							MODE_YIELD: begin
								if (target_kind == KIND_SELF ||
									(target_kind == KIND_SPEC && target_tid == cur_q)) begin
									res_d   = cur_q;
									state_d = ST_FIN;
								end else if (target_kind == KIND_SPEC) begin
									tgt_d       = target_tid;
									a_req.raddr = target_tid;
									state_d     = ST_YCHK;
								end else if (target_kind == KIND_ANY) begin
									if (count_q == '0) begin
										sts_d   = STS_NONE;
										state_d = ST_FIN;
									end else begin
										tgt_d       = head_q;
										res_d       = head_q;
										ul_ret_d    = ST_SW;
										a_req.raddr = head_q;
										state_d     = ST_LOAD;
									end
								end else begin
									sts_d   = STS_INVALID;
									state_d = ST_FIN;
								end
							end
							MODE_EXIT: begin
								res_d       = cur_q;
								tgt_d       = cur_q;
								a_req.we    = 1'b1;
								a_req.waddr = cur_q;
								state_d     = ST_PUSH;
							end
							default: begin
								if (target_tid == cur_q) begin
									sts_d   = STS_INVALID;
									state_d = ST_FIN;
								end else begin
									tgt_d       = target_tid;
									a_req.raddr = target_tid;
									state_d     = ST_KCHK;
								end
							end
						endcase
					end
				end
			end
			ST_CR: begin
				// popped id goes to the queue tail
				enq_d     = b_rdata;
				res_d     = b_rdata;
				enq_ret_d = ST_FIN;
				state_d   = ST_ENQ_W;
			end
			ST_ENQ_W: begin
				a_req.we       = 1'b1;
				a_req.waddr    = enq_q;
				a_req.wdata.st = TS_READY;
				a_req.wdata.prv = (count_q == '0) ? '0 : tail_q;
				if (count_q == '0) begin
					head_d  = enq_q;
					tail_d  = enq_q;
					count_d = count_q + 1'b1;
					state_d = enq_ret_q;
				end else begin
					a_req.raddr = tail_q;
					state_d     = ST_ENQ_TW;
				end
			end
			ST_ENQ_TW: begin
				a_req.we        = 1'b1;
				a_req.waddr     = tail_q;
				a_req.wdata     = rd;
				a_req.wdata.nxt = enq_q;
				tail_d          = enq_q;
				count_d         = count_q + 1'b1;
				state_d         = enq_ret_q;
			end
			ST_YCHK: begin
				if (rd.st == TS_FREE) begin
					sts_d   = STS_INVALID;
					state_d = ST_FIN;
				end else if (rd.st != TS_READY) begin
					sts_d   = STS_NONE;
					state_d = ST_FIN;
				end else begin
					e_d      = rd;
					res_d    = tgt_q;
					ul_ret_d = ST_SW;
					state_d  = ST_UL_H;
				end
			end
			ST_LOAD: begin
				e_d     = rd;
				state_d = ST_UL_H;
			end
			ST_UL_H: begin
				// unlink from the predecessor side
				if (tgt_q == head_q) begin
					head_d  = e_q.nxt;
					state_d = ST_UL_T;
				end else begin
					a_req.raddr = e_q.prv;
					state_d     = ST_UL_HW;
				end
			end
			ST_UL_HW: begin
				a_req.we        = 1'b1;
				a_req.waddr     = e_q.prv;
				a_req.wdata     = rd;
				a_req.wdata.nxt = e_q.nxt;
				state_d         = ST_UL_T;
			end
			ST_UL_T: begin
				// unlink from the successor side
				count_d = count_q - 1'b1;
				if (tgt_q == tail_q) begin
					tail_d  = e_q.prv;
					state_d = ul_ret_q;
				end else begin
					a_req.raddr = e_q.nxt;
					state_d     = ST_UL_TW;
				end
			end
			ST_UL_TW: begin
				a_req.we        = 1'b1;
				a_req.waddr     = e_q.nxt;
				a_req.wdata     = rd;
				a_req.wdata.prv = e_q.prv;
				state_d         = ul_ret_q;
			end
			ST_SW: begin
				// yielding thread goes to the tail
				enq_d     = cur_q;
				enq_ret_d = ST_RUN;
				state_d   = ST_ENQ_W;
			end
			ST_RUN: begin
				cur_d       = tgt_q;
				a_req.we    = 1'b1;
				a_req.waddr = tgt_q;
				if (e_q.kill) begin
					state_d = ST_PUSH;
				end else begin
					a_req.wdata.st = TS_RUNNING;
					state_d        = ST_FIN;
				end
			end
			ST_PUSH: begin
				// return the retired id to the free stack
				if (!free_q[CNT_W-1]) begin
					b_req.we    = 1'b1;
					b_req.waddr = free_q[TID_W-1:0];
					b_req.wdata = tgt_q;
					free_d      = free_q + 1'b1;
				end
				state_d = ST_DISP;
			end
			ST_DISP: begin
				if (count_q == '0) begin
					halted_d = 1'b1;
					state_d  = ST_FIN;
				end else begin
					tgt_d       = head_q;
					ul_ret_d    = ST_RUN;
					a_req.raddr = head_q;
					state_d     = ST_LOAD;
				end
			end
			ST_KCHK: begin
				if (rd.st == TS_FREE) begin
					sts_d = STS_INVALID;
				end else begin
					a_req.we         = 1'b1;
					a_req.waddr      = tgt_q;
					a_req.wdata      = rd;
					a_req.wdata.kill = 1'b1;
					res_d            = tgt_q;
				end
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// load the output register once it is free
				if (!ov_q || out_ready) begin
					ov_d    = 1'b1;
					osts_d  = halted_q ? STS_HALTED : sts_q;
					ores_d  = halted_q ? '0 : res_q;
					orun_d  = cur_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`TSQ_ASSERT_ALWAYS(a_count_bound, count_q + free_q <= CNT_W'(MAX_THREADS))
	`TSQ_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q)
	`TSQ_ASSERT_NEXT(a_accept_busy, acc, state_q != ST_IDLE)

endmodule

// File: rtl/thread_scheduler_fifo_ready_queue_unit.sv
// Hardware thread manager: takes create, yield, exit and kill commands, keeps a FIFO
// ready queue and a free-id stack in two RAMs with registered reads. After reset a clearing
// pass over all 1024 entries fills the tables before the first command is taken. A command
// holds the block through its read-modify-write steps on the thread table, and no new one
// is taken meanwhile; a yield or exit that runs into killed threads also retires each one.
// Depends on tsq_pkg, tsq_ram and tsq_ctrl.
module thread_scheduler_fifo_ready_queue_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic [1:0]                target_kind,
	input  logic [tsq_pkg::TID_W-1:0] target_tid,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                status,
	output logic [tsq_pkg::TID_W-1:0] result_tid,
	output logic [tsq_pkg::TID_W-1:0] running_tid
);
	import tsq_pkg::*;

	tmem_req_t        a_req;
	smem_req_t        b_req;
	logic [ENT_W-1:0] a_rdata;
	logic [TID_W-1:0] b_rdata;

	// command sequencer
	tsq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.target_kind (target_kind),
		.target_tid  (target_tid),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.result_tid  (result_tid),
		.running_tid (running_tid),
		.a_req       (a_req),
		.a_rdata     (a_rdata),
		.b_req       (b_req),
		.b_rdata     (b_rdata)
	);

	// thread table: state, kill mark and queue links
	tsq_ram #(.WIDTH(ENT_W), .DEPTH(MAX_THREADS)) u_thread_ram (
		.clk   (clk),
		.we    (a_req.we),
		.waddr (a_req.waddr),
		.wdata (a_req.wdata),
		.raddr (a_req.raddr),
		.rdata (a_rdata)
	);

	// free-id stack
	tsq_ram #(.WIDTH(TID_W), .DEPTH(MAX_THREADS)) u_free_ram (
		.clk   (clk),
		.we    (b_req.we),
		.waddr (b_req.waddr),
		.wdata (b_req.wdata),
		.raddr (b_req.raddr),
		.rdata (b_rdata)
	);

endmodule

// File: tb/tb.sv
// Testbench for the round-robin thread scheduler: directed, random and drain phases.
// A local scheduler model predicts every response; needs tsq_pkg and the scheduler RTL.
module tb;
	import tsq_pkg::*;

	typedef struct packed {
		logic [1:0]       mode;
		logic [1:0]       kind;
		logic [TID_W-1:0] tid;
	} cmd_t;

	typedef struct packed {
		sts_t             st;
		logic [TID_W-1:0] res;
		logic [TID_W-1:0] run;
	} resp_t;

	localparam int WDOG_LIMIT = 40000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       mode = MODE_CREATE;
	logic [1:0]       target_kind = KIND_SPEC;
	logic [TID_W-1:0] target_tid = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       status;
	logic [TID_W-1:0] result_tid;
	logic [TID_W-1:0] running_tid;

	// scheduler model state
	logic [1:0] thr_state [MAX_THREADS];
	bit         kill_mark [MAX_THREADS];
	int         ready_fifo [$];
	int         free_stk [MAX_THREADS];
	int         free_cnt;
	int         cur_tid;
	bit         halted;

	cmd_t  cmd_q [$];
	resp_t resp_q [$];
	bit    no_idle = 1'b0;
	int    errors = 0;
	int    sts_seen [5];
	int    idle_cnt = 0;

	thread_scheduler_fifo_ready_queue_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .target_kind(target_kind), .target_tid(target_tid),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_tid(result_tid), .running_tid(running_tid)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void sched_reset();
		for (int k = 0; k < MAX_THREADS; k++) begin
			thr_state[k] = TS_FREE;
			kill_mark[k] = 1'b0;
			free_stk[k] = MAX_THREADS - 1 - k;
		end
		thr_state[0] = TS_RUNNING;
		ready_fifo.delete();
		free_cnt = MAX_THREADS - 1;
		cur_tid = 0;
		halted = 1'b0;
	endfunction

	function automatic void unlink(int t);
		for (int k = 0; k < ready_fifo.size(); k++) begin
			if (ready_fifo[k] == t) begin
				ready_fifo.delete(k);
				break;
			end
		end
	endfunction

	function automatic void retire();
		thr_state[cur_tid] = TS_FREE;
		kill_mark[cur_tid] = 1'b0;
		if (free_cnt < MAX_THREADS) begin
			free_stk[free_cnt] = cur_tid;
			free_cnt++;
		end
	endfunction

	// run the queue head; killed threads exit on the spot
	function automatic void dispatch();
		forever begin
			if (ready_fifo.size() == 0) begin
				halted = 1'b1;
				return;
			end
			cur_tid = ready_fifo.pop_front();
			thr_state[cur_tid] = TS_RUNNING;
			if (!kill_mark[cur_tid])
				return;
			retire();
		end
	endfunction

	function automatic void switch_to(int t);
		thr_state[cur_tid] = TS_READY;
		ready_fifo.push_back(cur_tid);
		cur_tid = t;
		thr_state[t] = TS_RUNNING;
		if (kill_mark[t]) begin
			retire();
			dispatch();
		end
	endfunction

	function automatic resp_t sched_predict(cmd_t c);
		resp_t r;
		int    t;
		r.st = STS_OK;
		r.res = '0;
		if (halted) begin
			r.st = STS_HALTED;
		end else if (c.mode == MODE_CREATE) begin
			if (free_cnt == 0) begin
				r.st = STS_NOFREE;
			end else begin
				free_cnt--;
				t = free_stk[free_cnt];
				thr_state[t] = TS_READY;
				kill_mark[t] = 1'b0;
				ready_fifo.push_back(t);
				r.res = TID_W'(t);
			end
		end else if (c.mode == MODE_YIELD) begin
			if (c.kind == KIND_SELF || (c.kind == KIND_SPEC && c.tid == cur_tid)) begin
				r.res = TID_W'(cur_tid);
			end else if (c.kind == KIND_SPEC) begin
				if (thr_state[c.tid] == TS_FREE) begin
					r.st = STS_INVALID;
				end else if (thr_state[c.tid] != TS_READY) begin
					r.st = STS_NONE;
				end else begin
					unlink(c.tid);
					r.res = c.tid;
					switch_to(c.tid);
				end
			end else if (c.kind == KIND_ANY) begin
				if (ready_fifo.size() == 0) begin
					r.st = STS_NONE;
				end else begin
					t = ready_fifo.pop_front();
					r.res = TID_W'(t);
					switch_to(t);
				end
			end else begin
				r.st = STS_INVALID;
			end
			if (halted) begin
				r.st = STS_HALTED;
				r.res = '0;
			end
		end else if (c.mode == MODE_EXIT) begin
			r.res = TID_W'(cur_tid);
			retire();
			dispatch();
			if (halted) begin
				r.st = STS_HALTED;
				r.res = '0;
			end
		end else begin
			if (c.tid == cur_tid || thr_state[c.tid] == TS_FREE) begin
				r.st = STS_INVALID;
			end else begin
				kill_mark[c.tid] = 1'b1;
				r.res = c.tid;
			end
		end
		r.run = TID_W'(cur_tid);
		return r;
	endfunction

	// driver: hold a command until accepted, then predict its response
	always @(posedge clk or negedge arst_n) begin
		cmd_t c;
		logic nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nv = in_valid && !in_ready;
			if (in_valid && in_ready)
				resp_q.push_back(sched_predict('{mode, target_kind, target_tid}));
			if (!nv && cmd_q.size() != 0 && (no_idle || $urandom_range(99) >= 19)) begin
				c = cmd_q.pop_front();
				mode <= c.mode;
				target_kind <= c.kind;
				target_tid <= c.tid;
				nv = 1'b1;
			end
			in_valid <= nv;
		end
	end

	// monitor: stall at random and compare each response transaction
	always @(posedge clk or negedge arst_n) begin
		resp_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || $urandom_range(99) >= 19;
			if (out_valid && out_ready) begin
				if (resp_q.size() == 0) begin
					$error("response with no command pending");
					errors++;
				end else begin
					e = resp_q.pop_front();
					if (status < 5)
						sts_seen[status]++;
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						errors++;
					end
					if (result_tid !== e.res) begin
						$error("result_tid: expected %0d, got %0d", e.res, result_tid);
						errors++;
					end
					if (running_tid !== e.run) begin
						$error("running_tid: expected %0d, got %0d", e.run, running_tid);
						errors++;
					end
				end
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("watchdog expired with %0d responses outstanding", resp_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// wait until every queued command has been taken, so the model is current
	task automatic settle();
		while (cmd_q.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	// wait for the previous command to be taken, so the model is current
	task automatic send(logic [1:0] m, logic [1:0] k, int t);
		while (cmd_q.size() != 0 || in_valid)
			@(negedge clk);
		cmd_q.push_back('{m, k, t[TID_W-1:0]});
		@(negedge clk);
	endtask

	task automatic drain();
		while (cmd_q.size() != 0 || in_valid || resp_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic int pick_tid();
		int r;
		r = $urandom_range(99);
		if (r < 70 && ready_fifo.size() != 0)
			return ready_fifo[$urandom_range(ready_fifo.size() - 1)];
		if (r < 78)
			return cur_tid;
		if (r < 90)
			return $urandom_range(63);
		return $urandom_range(MAX_THREADS - 1);
	endfunction

	// an exit is safe while some queued thread has no kill mark
	function automatic bit exit_safe();
		foreach (ready_fifo[k])
			if (!kill_mark[ready_fifo[k]])
				return 1'b1;
		return 1'b0;
	endfunction

	initial begin
		int         live, r, k, t;
		logic [1:0] m, kd;
		sched_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty queue, invalid targets, kills and a killed switch
		send(MODE_YIELD, KIND_ANY, 0);
		send(MODE_KILL, KIND_SPEC, 0);
		send(MODE_KILL, KIND_SPEC, 1023);
		send(MODE_YIELD, KIND_SPEC, 1023);
		send(MODE_CREATE, KIND_SPEC, 0);
		send(MODE_CREATE, KIND_SPEC, 0);
		send(MODE_CREATE, KIND_SPEC, 0);
		send(MODE_YIELD, KIND_SELF, 1023);
		send(MODE_YIELD, KIND_SPEC, 0);
		send(MODE_YIELD, 2'd3, 5);
		send(MODE_YIELD, KIND_SPEC, 500);
		send(MODE_YIELD, KIND_SPEC, 3);
		send(MODE_YIELD, KIND_ANY, 0);
		send(MODE_KILL, KIND_SPEC, 2);
		send(MODE_KILL, KIND_SPEC, 2);
		send(MODE_KILL, KIND_SPEC, 500);
		send(MODE_YIELD, KIND_SPEC, 2);
		send(MODE_CREATE, KIND_ANY, 682);
		send(MODE_YIELD, KIND_ANY, 341);
		send(MODE_EXIT, KIND_SELF, 0);
		send(MODE_CREATE, KIND_SPEC, 0);
		drain();

		// random: live thread count kept moderate, no halt yet
		for (int n = 0; n < 1300; n++) begin
			settle();
			no_idle = (n >= 400 && n < 600);
			if (n == 900)
				drain();
			live = ready_fifo.size() + 1;
			r = $urandom_range(99);
			if (r < (live < 4 ? 45 : (live > 48 ? 8 : 22)))
				m = MODE_CREATE;
			else if (r < 70)
				m = MODE_YIELD;
			else if (r < 82)
				m = MODE_EXIT;
			else
				m = MODE_KILL;
			if (m == MODE_EXIT && !exit_safe())
				m = MODE_CREATE;
			r = $urandom_range(99);
			kd = r < 45 ? KIND_SPEC : (r < 80 ? KIND_ANY : (r < 95 ? KIND_SELF : 2'd3));
			send(m, kd, pick_tid());
		end
		no_idle = 1'b0;
		drain();

		// mark every queued thread, then one exit retires the whole chain and halts
		for (k = 0; k < ready_fifo.size(); k++) begin
			t = ready_fifo[k];
			send(MODE_KILL, KIND_SPEC, t);
		end
		send(MODE_EXIT, KIND_SPEC, 0);
		send(MODE_CREATE, KIND_SPEC, 0);
		send(MODE_YIELD, KIND_ANY, 0);
		send(MODE_KILL, KIND_SPEC, 1);
		drain();
		repeat (40) @(posedge clk);

		$display("covered directed cases, random traffic with stalls and a halting exit chain");
		$display("responses: ok %0d, invalid %0d, none ready %0d, no free id %0d, halted %0d",
			sts_seen[0], sts_seen[1], sts_seen[2], sts_seen[3], sts_seen[4]);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tsq_pkg.sv
rtl/tsq_ram.sv
rtl/tsq_ctrl.sv
rtl/thread_scheduler_fifo_ready_queue_unit.sv
tb/tb.sv
